// ===== rtl/hmmv_pkg.sv =====
// ----------------------------------------------------------------------------
// hmmv_pkg
// Shared types, sizes and helpers for the hmm viterbi path decoder.
// ----------------------------------------------------------------------------
package hmmv_pkg;

    localparam int NUM_STATES  = 5;
    localparam int NUM_SYMBOLS = 32;
    localparam int MAX_STEPS   = 64;

    localparam int ST_W   = 3;
    localparam int SYM_W  = 5;
    localparam int COL_W  = 5;
    localparam int COST_W = 16;
    localparam int MET_W  = 24;
    localparam int TS_W   = 6;
    localparam int OP_W   = 2;
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int SI_W   = $clog2(NUM_STATES);

    localparam int TR_DEPTH = NUM_STATES * NUM_STATES;
    localparam int EM_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int BP_DEPTH = MAX_STEPS * NUM_STATES;
    localparam int TR_AW    = $clog2(TR_DEPTH);
    localparam int EM_AW    = $clog2(EM_DEPTH);
    localparam int BP_AW    = $clog2(BP_DEPTH);

    localparam logic [COST_W-1:0] COST_INF   = '1;
    localparam logic [MET_W-1:0]  METRIC_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WR_TRANS = 2'd0,
        OP_WR_EMIT  = 2'd1,
        OP_WR_INIT  = 2'd2,
        OP_OBSERVE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT_RD,
        S_ACS_RD,
        S_ACS,
        S_ACS_DONE,
        S_BEST,
        S_BT_RD,
        S_BT_OUT,
        S_BT_WAIT
    } state_t;

    // saturating cost add: metric plus table cost
    function automatic logic [MET_W-1:0] add_cost(input logic [MET_W-1:0] m,
                                                  input logic [COST_W-1:0] c);
        logic [MET_W:0] s;
        s = {1'b0, m} + {{(MET_W + 1 - COST_W){1'b0}}, c};
        if (m == METRIC_MAX || c == COST_INF || s >= {1'b0, METRIC_MAX})
            return METRIC_MAX;
        return s[MET_W-1:0];
    endfunction

endpackage

// ===== rtl/hmmv_ram.sv =====
// ----------------------------------------------------------------------------
// hmmv_ram
// Generic single write port ram with registered read.
// ----------------------------------------------------------------------------
module hmmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/hmm_viterbi_path_decoder.sv =====
// ----------------------------------------------------------------------------
// hmm_viterbi_path_decoder
// Log domain viterbi decoder with one shared add-compare-select unit.
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  s_       | in        | op, row_state, column, cost, symbol, last_symbol
//  m_       | out       | time_step, best_state, path_cost, last
//
//  an observation runs state-wise emission reads after the word, then a transition
//  read and an acs step per predecessor and one select per state, then the best state
//  pick; the first step of a run uses one init cost step per state instead of these
//  backtrace passes S_BT_OUT, S_BT_RD and S_BT_WAIT per path word, waiting for m_ready
//  reset clears the sequencer, step count, path metrics and emission capture flag only
//  s_ready is low while an observation or backtrace is in progress
module hmm_viterbi_path_decoder
    import hmmv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [ST_W-1:0]   s_row_state,
    input  logic [COL_W-1:0]  s_column,
    input  logic [COST_W-1:0] s_cost,
    input  logic [SYM_W-1:0]  s_symbol,
    input  logic              s_last_symbol,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [TS_W-1:0]   m_time_step,
    output logic [ST_W-1:0]   m_best_state,
    output logic [MET_W-1:0]  m_path_cost,
    output logic              m_last
);
    state_t state_reg, state_next;

    logic [MET_W-1:0]  pm_reg [NUM_STATES];
    logic [MET_W-1:0]  nx_reg [NUM_STATES];
    logic [COST_W-1:0] init_reg [NUM_STATES];   // tiny table, fixed reads
    logic [COST_W-1:0] emit_reg [NUM_STATES];
    logic [CNT_W-1:0]  cnt_reg;                 // step count
    logic [SI_W-1:0]   i_reg, j_reg;
    logic [MET_W-1:0]  min_reg;
    logic [SI_W-1:0]   arg_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              fin_reg;
    logic [TS_W-1:0]   t_reg;
    logic [SI_W-1:0]   q_reg;
    logic [MET_W-1:0]  best_reg;

    // table write decode
    logic s_acc;
    assign s_acc = s_valid && s_ready;
    logic row_ok;
    assign row_ok = {1'b0, s_row_state} < (ST_W + 1)'(NUM_STATES);

    logic tr_we, em_we;
    assign tr_we = s_acc && s_op == OP_WR_TRANS && row_ok
                   && {1'b0, s_column} < (COL_W + 1)'(NUM_STATES);
    assign em_we = s_acc && s_op == OP_WR_EMIT && row_ok
                   && {1'b0, s_column} < (COL_W + 1)'(NUM_SYMBOLS);

    logic [TR_AW-1:0] tr_waddr, tr_raddr;
    logic [EM_AW-1:0] em_waddr, em_raddr;
    logic [COST_W-1:0] tr_rdata, em_rdata;
    assign tr_waddr = TR_AW'(s_row_state * NUM_STATES + s_column);
    assign em_waddr = EM_AW'(s_row_state * NUM_SYMBOLS + s_column);

    hmmv_ram #(.WIDTH(COST_W), .DEPTH(TR_DEPTH)) u_trans (
        .aclk(aclk), .we(tr_we), .waddr(tr_waddr), .wdata(s_cost),
        .raddr(tr_raddr), .rdata(tr_rdata)
    );
    hmmv_ram #(.WIDTH(COST_W), .DEPTH(EM_DEPTH)) u_emit (
        .aclk(aclk), .we(em_we), .waddr(em_waddr), .wdata(s_cost),
        .raddr(em_raddr), .rdata(em_rdata)
    );

    // backpointer store
    logic             bp_we;
    logic [BP_AW-1:0] bp_waddr, bp_raddr;
    logic [ST_W-1:0]  bp_rdata;
    logic [TS_W-1:0]  t_cur;
    assign t_cur    = cnt_reg[TS_W-1:0];
    assign bp_waddr = BP_AW'(t_cur * NUM_STATES + j_reg);
    assign bp_raddr = BP_AW'(t_reg * NUM_STATES + q_reg);

    hmmv_ram #(.WIDTH(ST_W), .DEPTH(BP_DEPTH)) u_bp (
        .aclk(aclk), .we(bp_we), .waddr(bp_waddr), .wdata(ST_W'(arg_reg)),
        .raddr(bp_raddr), .rdata(bp_rdata)
    );

    // emission read walks states, acs reads transition[i][j]
    assign tr_raddr = TR_AW'(i_reg * NUM_STATES + j_reg);
    assign em_raddr = EM_AW'(j_reg * NUM_SYMBOLS + sym_reg);

    // shared add-compare-select unit
    logic [MET_W-1:0] acs_sum;
    assign acs_sum = add_cost(pm_reg[i_reg], tr_rdata);

    logic last_i, last_j, first_step;
    assign last_i     = i_reg == SI_W'(NUM_STATES - 1);
    assign last_j     = j_reg == SI_W'(NUM_STATES - 1);
    assign first_step = cnt_reg == '0;

    logic sym_ok;
    assign sym_ok = {1'b0, sym_reg} < (SYM_W + 1)'(NUM_SYMBOLS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        bp_we      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_op == OP_OBSERVE) begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                // read in flight for j_reg, capture next cycle
                if (last_j) begin
                    state_next = S_ACS_RD;
                end
            end
            S_ACS_RD: state_next = S_ACS;
            S_ACS: begin
                if (last_i || first_step) begin
                    state_next = S_ACS_DONE;
                end else begin
                    state_next = S_ACS_RD;
                end
            end
            S_ACS_DONE: begin
                bp_we = 1'b1;
                if (last_j) begin
                    state_next = S_BEST;
                end else begin
                    state_next = S_ACS_RD;
                end
            end
            S_BEST: begin
                // count still holds this step's index, full once it is the last slot
                if (fin_reg || cnt_reg == CNT_W'(MAX_STEPS - 1)) begin
                    state_next = S_BT_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_BT_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = (t_reg == '0) ? S_IDLE : S_BT_RD;
                end
            end
            S_BT_RD:   state_next = S_BT_WAIT;
            S_BT_WAIT: state_next = S_BT_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    // init table in flops, five fixed entries
    always_ff @(posedge aclk) begin
        if (s_acc && s_op == OP_WR_INIT && row_ok) begin
            init_reg[SI_W'(s_row_state)] <= s_cost;
        end
    end

    // best final state search is a small fixed compare chain
    logic [SI_W-1:0]  fbest;
    logic [MET_W-1:0] fmin;
    always_comb begin
        fbest = '0;
        fmin  = nx_reg[0];
        for (int k = 1; k < NUM_STATES; k++) begin
            if (nx_reg[k] < fmin) begin
                fmin  = nx_reg[k];
                fbest = SI_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int k = 0; k < NUM_STATES; k++) begin
                pm_reg[k] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_op == OP_OBSERVE) begin
                        sym_reg <= s_symbol;
                        fin_reg <= s_last_symbol;
                        j_reg   <= '0;
                        i_reg   <= '0;
                        if (cnt_reg >= CNT_W'(MAX_STEPS)) begin
                            cnt_reg <= '0;
                        end
                    end
                end
                S_EMIT_RD: begin
                    j_reg <= last_j ? '0 : j_reg + 1'b1;
                end
                S_ACS_RD: ;
                S_ACS: begin
                    if (first_step) begin
                        min_reg <= add_cost('0, init_reg[j_reg]);
                        arg_reg <= '0;
                    end else if (i_reg == '0 || acs_sum < min_reg) begin
                        min_reg <= acs_sum;
                        arg_reg <= i_reg;
                    end
                    i_reg <= (last_i || first_step) ? '0 : i_reg + 1'b1;
                end
                S_ACS_DONE: begin
                    nx_reg[j_reg] <= add_cost(min_reg, emit_reg[j_reg]);
                    j_reg <= last_j ? '0 : j_reg + 1'b1;
                end
                S_BEST: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    t_reg   <= t_cur;
                    q_reg   <= fbest;
                    best_reg <= fmin;
                    for (int k = 0; k < NUM_STATES; k++) begin
                        pm_reg[k] <= nx_reg[k];
                    end
                end
                S_BT_OUT: begin
                    if (m_ready) begin
                        if (t_reg == '0) begin
                            cnt_reg <= '0;
                            for (int k = 0; k < NUM_STATES; k++) begin
                                pm_reg[k] <= '0;
                            end
                        end
                    end
                end
                S_BT_RD: ;
                S_BT_WAIT: begin
                    // bp read of step t, then move to t-1
                    q_reg <= ({1'b0, bp_rdata} < (ST_W + 1)'(NUM_STATES))
                             ? SI_W'(bp_rdata) : '0;
                    t_reg <= t_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // emission capture in the cycle after each read
    logic [SI_W-1:0] ej_reg;
    logic            ecap_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecap_reg <= 1'b0;
        end else begin
            ecap_reg <= state_reg == S_EMIT_RD;
        end
        ej_reg <= j_reg;
        if (ecap_reg) begin
            emit_reg[ej_reg] <= sym_ok ? em_rdata : COST_INF;
        end
    end

    assign m_time_step  = t_reg;
    assign m_best_state = ST_W'(q_reg);
    assign m_path_cost  = best_reg;
    assign m_last       = t_reg == '0;
endmodule
